>>> hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros shared by the RTL. Empty when SYNTHESIS is set.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// property must hold at every clock edge out of reset
`define MC_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// expression must never be true out of reset
`define MC_ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define MC_ASSERT(lbl, clk, rst_n, prop, msg)
`define MC_ASSERT_NEVER(lbl, clk, rst_n, expr, msg)
`endif
`endif

>>> hw/rtl/mcconv_pkg.sv
// ----------------------------------------------------------------------------
// mcconv_pkg
// Types, field layout and constants of the multi-channel convolution unit.
// ----------------------------------------------------------------------------
package mcconv_pkg;

  // default store dimensions
  localparam int DEF_MAX_IMG_W    = 64;
  localparam int DEF_MAX_IMG_H    = 64;
  localparam int DEF_MAX_CHANNELS = 4;
  localparam int DEF_MAX_FILT_W   = 5;
  localparam int DEF_MAX_FILT_H   = 5;
  localparam int DEF_MAX_FILTERS  = 8;

  // input fields
  localparam int FUNC_W = 2;
  localparam int FI_W   = 3;
  localparam int CI_W   = 2;
  localparam int ROW_W  = 6;
  localparam int COL_W  = 6;
  localparam int VAL_W  = 16;

  localparam int FI_LSB  = 0;
  localparam int CI_LSB  = FI_LSB + FI_W;
  localparam int ROW_LSB = CI_LSB + CI_W;
  localparam int COL_LSB = ROW_LSB + ROW_W;
  localparam int VAL_LSB = COL_LSB + COL_W;
  localparam int IN_BITS = VAL_LSB + VAL_W;
  localparam int S_TDATA_W = ((IN_BITS + 7) / 8) * 8;

  // result fields
  localparam int SUM_W     = 40;
  localparam int M_TDATA_W = SUM_W;
  localparam int PROD_W    = 2 * VAL_W;

  localparam logic signed [SUM_W-1:0] SUM_MAX = 40'sh7F_FFFF_FFFF;
  localparam logic signed [SUM_W-1:0] SUM_MIN = 40'sh80_0000_0000;

  // configuration registers
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 7;
  localparam int CFG_IW_W   = 7;
  localparam int CFG_IH_W   = 7;
  localparam int CFG_FW_W   = 3;
  localparam int CFG_FH_W   = 3;
  localparam int CFG_NC_W   = 3;
  localparam int CFG_NF_W   = 4;

  localparam logic [CFG_IW_W-1:0] RST_IMAGE_WIDTH   = 7'd64;
  localparam logic [CFG_IH_W-1:0] RST_IMAGE_HEIGHT  = 7'd64;
  localparam logic [CFG_FW_W-1:0] RST_FILTER_WIDTH  = 3'd3;
  localparam logic [CFG_FH_W-1:0] RST_FILTER_HEIGHT = 3'd3;
  localparam logic [CFG_NC_W-1:0] RST_CHANNEL_COUNT = 3'd1;
  localparam logic [CFG_NF_W-1:0] RST_FILTER_COUNT  = 4'd1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAGE_WIDTH   = 3'd0,
    REG_IMAGE_HEIGHT  = 3'd1,
    REG_FILTER_WIDTH  = 3'd2,
    REG_FILTER_HEIGHT = 3'd3,
    REG_CHANNEL_COUNT = 3'd4,
    REG_FILTER_COUNT  = 3'd5
  } reg_idx_e;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_PIXEL   = 2'd0,
    FUNC_WEIGHT  = 2'd1,
    FUNC_COMPUTE = 2'd2
  } func_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic wr_pix;
    logic wr_wgt;
    logic start;
    logic step;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic              range_err;
    logic              last;
    logic              busy;
    logic              out_full;
  } status_t;

endpackage

>>> hw/rtl/mcconv_dp.sv
// ----------------------------------------------------------------------------
// mcconv_dp
// Config registers, pixel and weight stores, tap counters, MAC pipeline and
// result register.
// ----------------------------------------------------------------------------
module mcconv_dp #(
  parameter int MAX_IMG_W    = mcconv_pkg::DEF_MAX_IMG_W,
  parameter int MAX_IMG_H    = mcconv_pkg::DEF_MAX_IMG_H,
  parameter int MAX_CHANNELS = mcconv_pkg::DEF_MAX_CHANNELS,
  parameter int MAX_FILT_W   = mcconv_pkg::DEF_MAX_FILT_W,
  parameter int MAX_FILT_H   = mcconv_pkg::DEF_MAX_FILT_H,
  parameter int MAX_FILTERS  = mcconv_pkg::DEF_MAX_FILTERS
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [mcconv_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [mcconv_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  logic [mcconv_pkg::S_TDATA_W-1:0]   in_data_i,
  input  logic [mcconv_pkg::FUNC_W-1:0]      in_func_i,
  input  mcconv_pkg::cmd_t                   cmd_i,
  output mcconv_pkg::status_t                status_o,
  input  logic                               out_ready_i,
  output logic                               out_valid_o,
  output logic [mcconv_pkg::M_TDATA_W-1:0]   out_data_o,
  output logic                               out_err_o
);
  import mcconv_pkg::*;

  localparam int IMG_PLANE = MAX_IMG_H * MAX_IMG_W;
  localparam int IMG_DEPTH = MAX_CHANNELS * IMG_PLANE;
  localparam int FLT_PLANE = MAX_FILT_H * MAX_FILT_W;
  localparam int FLT_BANK  = MAX_CHANNELS * FLT_PLANE;
  localparam int FLT_DEPTH = MAX_FILTERS * FLT_BANK;
  localparam int IMG_AW    = (IMG_DEPTH > 1) ? $clog2(IMG_DEPTH) : 1;
  localparam int FLT_AW    = (FLT_DEPTH > 1) ? $clog2(FLT_DEPTH) : 1;
  localparam int CH_W      = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int KW_W      = (MAX_FILT_W > 1) ? $clog2(MAX_FILT_W) : 1;
  localparam int KH_W      = (MAX_FILT_H > 1) ? $clog2(MAX_FILT_H) : 1;
  localparam int TAPS      = MAX_CHANNELS * FLT_PLANE;
  localparam int ACC_GROW  = PROD_W + $clog2(TAPS + 1);
  localparam int ACC_W     = (ACC_GROW > SUM_W + 1) ? ACC_GROW : SUM_W + 1;
  localparam logic signed [ACC_W-1:0] ACC_HI = ACC_W'(SUM_MAX);
  localparam logic signed [ACC_W-1:0] ACC_LO = ACC_W'(SUM_MIN);

  // config registers (raw values as written)
  logic [CFG_IW_W-1:0] iw_raw_q;
  logic [CFG_IH_W-1:0] ih_raw_q;
  logic [CFG_FW_W-1:0] fw_raw_q;
  logic [CFG_FH_W-1:0] fh_raw_q;
  logic [CFG_NC_W-1:0] nc_raw_q;
  logic [CFG_NF_W-1:0] nf_raw_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      iw_raw_q <= RST_IMAGE_WIDTH;
      ih_raw_q <= RST_IMAGE_HEIGHT;
      fw_raw_q <= RST_FILTER_WIDTH;
      fh_raw_q <= RST_FILTER_HEIGHT;
      nc_raw_q <= RST_CHANNEL_COUNT;
      nf_raw_q <= RST_FILTER_COUNT;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_IMAGE_WIDTH:   iw_raw_q <= cfg_data_i[CFG_IW_W-1:0];
        REG_IMAGE_HEIGHT:  ih_raw_q <= cfg_data_i[CFG_IH_W-1:0];
        REG_FILTER_WIDTH:  fw_raw_q <= cfg_data_i[CFG_FW_W-1:0];
        REG_FILTER_HEIGHT: fh_raw_q <= cfg_data_i[CFG_FH_W-1:0];
        REG_CHANNEL_COUNT: nc_raw_q <= cfg_data_i[CFG_NC_W-1:0];
        REG_FILTER_COUNT:  nf_raw_q <= cfg_data_i[CFG_NF_W-1:0];
        default: ;
      endcase
    end
  end

  // effective sizes, saturated into their legal ranges
  logic [CFG_IW_W-1:0] iw_eff, fw_hi;
  logic [CFG_IH_W-1:0] ih_eff, fh_hi;
  logic [CFG_FW_W-1:0] fw_eff;
  logic [CFG_FH_W-1:0] fh_eff;
  logic [CFG_NC_W-1:0] nc_eff;
  logic [CFG_NF_W-1:0] nf_eff;

  always_comb begin
    iw_eff = (iw_raw_q == '0) ? CFG_IW_W'(1) :
             ((32'(iw_raw_q) > MAX_IMG_W) ? CFG_IW_W'(MAX_IMG_W) : iw_raw_q);
    ih_eff = (ih_raw_q == '0) ? CFG_IH_W'(1) :
             ((32'(ih_raw_q) > MAX_IMG_H) ? CFG_IH_W'(MAX_IMG_H) : ih_raw_q);
    fw_hi  = (32'(iw_eff) < MAX_FILT_W) ? iw_eff : CFG_IW_W'(MAX_FILT_W);
    fh_hi  = (32'(ih_eff) < MAX_FILT_H) ? ih_eff : CFG_IH_W'(MAX_FILT_H);
    fw_eff = (fw_raw_q == '0) ? CFG_FW_W'(1) :
             ((CFG_IW_W'(fw_raw_q) > fw_hi) ? CFG_FW_W'(fw_hi) : fw_raw_q);
    fh_eff = (fh_raw_q == '0) ? CFG_FH_W'(1) :
             ((CFG_IH_W'(fh_raw_q) > fh_hi) ? CFG_FH_W'(fh_hi) : fh_raw_q);
    nc_eff = (nc_raw_q == '0) ? CFG_NC_W'(1) :
             ((32'(nc_raw_q) > MAX_CHANNELS) ? CFG_NC_W'(MAX_CHANNELS) : nc_raw_q);
    nf_eff = (nf_raw_q == '0) ? CFG_NF_W'(1) :
             ((32'(nf_raw_q) > MAX_FILTERS) ? CFG_NF_W'(MAX_FILTERS) : nf_raw_q);
  end

  // input field decode
  logic [FI_W-1:0]         in_fi;
  logic [CI_W-1:0]         in_ci;
  logic [ROW_W-1:0]        in_row;
  logic [COL_W-1:0]        in_col;
  logic signed [VAL_W-1:0] in_val;

  assign in_fi  = in_data_i[FI_LSB +: FI_W];
  assign in_ci  = in_data_i[CI_LSB +: CI_W];
  assign in_row = in_data_i[ROW_LSB +: ROW_W];
  assign in_col = in_data_i[COL_LSB +: COL_W];
  assign in_val = in_data_i[VAL_LSB +: VAL_W];

  // output position must leave room for the whole kernel, and the filter index must be below the filter count
  logic range_err;
  assign range_err = (8'(in_col) + 8'(fw_eff) > 8'(iw_eff)) ||
                     (8'(in_row) + 8'(fh_eff) > 8'(ih_eff)) ||
                     (CFG_NF_W'(in_fi) >= nf_eff);

  // store writes; anything outside the store dimensions is dropped
  logic              pix_we, wgt_we;
  logic [IMG_AW-1:0] img_waddr;
  logic [FLT_AW-1:0] flt_waddr;

  assign pix_we = cmd_i.wr_pix && (32'(in_ci) < MAX_CHANNELS) &&
                  (32'(in_row) < MAX_IMG_H) && (32'(in_col) < MAX_IMG_W);
  assign wgt_we = cmd_i.wr_wgt && (32'(in_fi) < MAX_FILTERS) &&
                  (32'(in_ci) < MAX_CHANNELS) && (32'(in_row) < MAX_FILT_H) &&
                  (32'(in_col) < MAX_FILT_W);

  assign img_waddr = IMG_AW'(in_ci) * IMG_AW'(IMG_PLANE) +
                     IMG_AW'(in_row) * IMG_AW'(MAX_IMG_W) + IMG_AW'(in_col);
  assign flt_waddr = FLT_AW'(in_fi) * FLT_AW'(FLT_BANK) +
                     FLT_AW'(in_ci) * FLT_AW'(FLT_PLANE) +
                     FLT_AW'(in_row) * FLT_AW'(MAX_FILT_W) + FLT_AW'(in_col);

  // latched compute request
  logic [FI_W-1:0]  fi_q;
  logic [ROW_W-1:0] row_q;
  logic [COL_W-1:0] col_q;
  logic             err_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      fi_q  <= in_fi;
      row_q <= in_row;
      col_q <= in_col;
      err_q <= range_err;
    end
  end

  // tap counters: channel outer, kernel column, kernel row inner
  logic [CH_W-1:0] c_q;
  logic [KW_W-1:0] a_q;
  logic [KH_W-1:0] b_q;
  logic            a_end, b_end, c_end;

  assign b_end = (b_q == KH_W'(fh_eff - CFG_FH_W'(1)));
  assign a_end = (a_q == KW_W'(fw_eff - CFG_FW_W'(1)));
  assign c_end = (c_q == CH_W'(nc_eff - CFG_NC_W'(1)));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_q <= '0;
      a_q <= '0;
      b_q <= '0;
    end else if (cmd_i.start) begin
      c_q <= '0;
      a_q <= '0;
      b_q <= '0;
    end else if (cmd_i.step) begin
      if (b_end) begin
        b_q <= '0;
        if (a_end) begin
          a_q <= '0;
          c_q <= c_q + CH_W'(1);
        end else begin
          a_q <= a_q + KW_W'(1);
        end
      end else begin
        b_q <= b_q + KH_W'(1);
      end
    end
  end

  // flipped kernel indices
  logic [KW_W-1:0]   wc;
  logic [KH_W-1:0]   wr;
  logic [IMG_AW-1:0] img_raddr;
  logic [FLT_AW-1:0] flt_raddr;

  assign wc = KW_W'(4'(fw_eff) - 4'd1 - 4'(a_q));
  assign wr = KH_W'(4'(fh_eff) - 4'd1 - 4'(b_q));

  assign img_raddr = IMG_AW'(c_q) * IMG_AW'(IMG_PLANE) +
                     (IMG_AW'(row_q) + IMG_AW'(b_q)) * IMG_AW'(MAX_IMG_W) +
                     IMG_AW'(col_q) + IMG_AW'(a_q);
  assign flt_raddr = FLT_AW'(fi_q) * FLT_AW'(FLT_BANK) +
                     FLT_AW'(c_q) * FLT_AW'(FLT_PLANE) +
                     FLT_AW'(wr) * FLT_AW'(MAX_FILT_W) + FLT_AW'(wc);

  // stores: one write and one registered read per cycle each
  logic signed [VAL_W-1:0] img_mem [IMG_DEPTH];
  logic signed [VAL_W-1:0] flt_mem [FLT_DEPTH];
  logic signed [VAL_W-1:0] pix_q, wgt_q;

  always_ff @(posedge clk_i) begin
    if (pix_we) begin
      img_mem[img_waddr] <= in_val;
    end
    pix_q <= img_mem[img_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (wgt_we) begin
      flt_mem[flt_waddr] <= in_val;
    end
    wgt_q <= flt_mem[flt_raddr];
  end

  // MAC pipeline: read -> multiply -> accumulate
  logic                     rd_vld_q, mul_vld_q;
  logic signed [PROD_W-1:0] prod_q;
  logic signed [ACC_W-1:0]  acc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_vld_q  <= 1'b0;
      mul_vld_q <= 1'b0;
    end else begin
      rd_vld_q  <= cmd_i.step;
      mul_vld_q <= rd_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= pix_q * wgt_q;
    if (cmd_i.start) begin
      acc_q <= '0;
    end else if (mul_vld_q) begin
      acc_q <= acc_q + ACC_W'(prod_q);
    end
  end

  // saturate into the result range; zero for an out-of-range request
  logic signed [SUM_W-1:0] sum_sat;

  always_comb begin
    if (err_q) begin
      sum_sat = '0;
    end else if (acc_q > ACC_HI) begin
      sum_sat = SUM_MAX;
    end else if (acc_q < ACC_LO) begin
      sum_sat = SUM_MIN;
    end else begin
      sum_sat = acc_q[SUM_W-1:0];
    end
  end

  // result register
  logic             out_vld_q;
  logic [SUM_W-1:0] out_sum_q;
  logic             out_err_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_vld_q <= 1'b1;
    end else if (out_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_sum_q <= sum_sat;
      out_err_q <= err_q;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_sum_q;
  assign out_err_o   = out_err_q;

  assign status_o.func      = in_func_i;
  assign status_o.range_err = range_err;
  assign status_o.last      = c_end && a_end && b_end;
  assign status_o.busy      = rd_vld_q || mul_vld_q;
  assign status_o.out_full  = out_vld_q && !out_ready_i;

endmodule

>>> hw/rtl/mcconv_ctrl.sv
// ----------------------------------------------------------------------------
// mcconv_ctrl
// Sequencer: takes input transactions, steps the tap loop, drains the MAC
// pipeline and hands the sum to the result register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mcconv_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  mcconv_pkg::status_t  status_i,
  output mcconv_pkg::cmd_t     cmd_o
);
  import mcconv_pkg::*;

  state_e state_q, state_d;
  logic   in_fire;

  assign in_fire = in_valid_i && (state_q == ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_fire && (status_i.func == FUNC_COMPUTE)) begin
          state_d = status_i.range_err ? ST_DONE : ST_RUN;
        end
      end
      ST_RUN: begin
        if (status_i.last) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!status_i.busy) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!status_i.out_full) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready_o     = 1'b0;
    cmd_o          = '0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o   = 1'b1;
        cmd_o.wr_pix = in_fire && (status_i.func == FUNC_PIXEL);
        cmd_o.wr_wgt = in_fire && (status_i.func == FUNC_WEIGHT);
        cmd_o.start  = in_fire && (status_i.func == FUNC_COMPUTE);
      end
      ST_RUN: begin
        cmd_o.step = 1'b1;
      end
      ST_DRAIN: ;
      ST_DONE: begin
        cmd_o.load_out = !status_i.out_full;
      end
      default: ;
    endcase
  end

  `MC_ASSERT(a_step_enters_pipe, clk_i, rst_ni, cmd_o.step |=> status_i.busy, "read lost")
  `MC_ASSERT_NEVER(a_load_while_busy, clk_i, rst_ni, cmd_o.load_out && status_i.busy, "sum not drained")
  `MC_ASSERT_NEVER(a_accept_while_busy, clk_i, rst_ni, in_ready_o && status_i.busy, "accept during MAC")

endmodule

>>> hw/rtl/multichannel_conv2d_unit.sv
// ----------------------------------------------------------------------------
// multichannel_conv2d_unit - multi-channel 2D valid-mode convolution engine
// Pixel and weight writes: a new transaction accepted every cycle while no compute runs.
// Compute, N = channel_count*filter_width*filter_height: N taps through a single MAC (store
// read, multiply, accumulate), then drain, then the result register is loaded; out of range:
// loaded directly. Next transaction accepted after the load, later while a result waits.
// Reset clears config (64,64,3,3,1,1) and control; the stores are not cleared.
// ----------------------------------------------------------------------------
module multichannel_conv2d_unit #(
  parameter int MAX_IMG_W    = mcconv_pkg::DEF_MAX_IMG_W,
  parameter int MAX_IMG_H    = mcconv_pkg::DEF_MAX_IMG_H,
  parameter int MAX_CHANNELS = mcconv_pkg::DEF_MAX_CHANNELS,
  parameter int MAX_FILT_W   = mcconv_pkg::DEF_MAX_FILT_W,
  parameter int MAX_FILT_H   = mcconv_pkg::DEF_MAX_FILT_H,
  parameter int MAX_FILTERS  = mcconv_pkg::DEF_MAX_FILTERS
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // configuration write port
  input  logic                              cfg_we_i,
  input  logic [mcconv_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [mcconv_pkg::CFG_DATA_W-1:0] cfg_data_i,
  // request stream
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // [2:0] filter_index, [4:3] channel_index, [10:5] row, [16:11] col,
  // [32:17] value, [39:33] zero
  input  logic [mcconv_pkg::S_TDATA_W-1:0]  s_axis_tdata,
  // [1:0] func
  input  logic [mcconv_pkg::FUNC_W-1:0]     s_axis_tuser,
  // result stream
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // [39:0] pixel_sum
  output logic [mcconv_pkg::M_TDATA_W-1:0]  m_axis_tdata,
  // [0] range_error
  output logic                              m_axis_tuser
);
  import mcconv_pkg::*;

  // Operation, per transaction on the request stream:
  //  - pixel / weight write: stored at once unless outside the store bounds.
  //  - compute: bounds checked against the saturated config; out of range
  //    returns zero with range_error, otherwise the controller walks all
  //    channel/tap pairs through one MAC and the sum saturates to 40 bits.
  // The result register decouples the result stream: further transactions are
  // accepted while a result waits; a finishing compute holds in its done
  // state until the register is free.

  cmd_t    cmd;
  status_t status;

  mcconv_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  mcconv_dp #(
    .MAX_IMG_W    (MAX_IMG_W),
    .MAX_IMG_H    (MAX_IMG_H),
    .MAX_CHANNELS (MAX_CHANNELS),
    .MAX_FILT_W   (MAX_FILT_W),
    .MAX_FILT_H   (MAX_FILT_H),
    .MAX_FILTERS  (MAX_FILTERS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_data_i   (s_axis_tdata),
    .in_func_i   (s_axis_tuser),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_data_o  (m_axis_tdata),
    .out_err_o   (m_axis_tuser)
  );

endmodule
